>>> sv/fvpt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the flame variation point transform.
package fvpt_pkg;

    localparam int MAX_TRANSFORMS      = 16;
    localparam int VARIATION_COUNT     = 6;
    localparam int WORDS_PER_TRANSFORM = 12;
    localparam int WEIGHT_BASE         = 6;
    localparam int MEM_DEPTH           = MAX_TRANSFORMS * WORDS_PER_TRANSFORM;
    localparam int MEM_AW              = $clog2(MEM_DEPTH);
    localparam int SUM_W               = 35;
    localparam int CORDIC_STEPS        = 24;
    localparam int ROOT_BITS           = 32;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [2:0] VAR_LINEAR = 3'd0;
    localparam logic [2:0] VAR_SINUS  = 3'd1;
    localparam logic [2:0] VAR_SPHERE = 3'd2;
    localparam logic [2:0] VAR_SWIRL  = 3'd3;
    localparam logic [2:0] VAR_HORSE  = 3'd4;
    localparam logic [2:0] VAR_POLAR  = 3'd5;

    localparam logic signed [33:0] QUARTER_TURN  = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN     = 34'sd2147483648;
    localparam logic signed [32:0] TURNS_PER_RAD = 33'sd683565276;
    localparam logic signed [65:0] CORDIC_GAIN   = 66'sd652032874;
    localparam logic signed [67:0] SAT_MAX       = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN       = -68'sd2147483648;
    localparam logic signed [67:0] ONE_Q16       = 68'sd65536;

    localparam logic [29:0] CORDIC_ANGLE [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004757, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
    };

    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
    } fvpt_dreq_t;

    typedef struct packed {
        logic        done;
        logic        clip;
        logic [31:0] quot;
        logic [31:0] root;
    } fvpt_dres_t;

    typedef struct packed {
        logic        start;
        logic        vec;
        logic [31:0] phase;
        logic [31:0] px;
        logic [31:0] py;
    } fvpt_creq_t;

    typedef struct packed {
        logic        done;
        logic [32:0] sin_q30;
        logic [32:0] cos_q30;
        logic [33:0] angle;
    } fvpt_cres_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [67:0] v);
        sat_t s;
        if (v > SAT_MAX) begin
            s.ovf = 1'b1;
            s.val = 32'h7fff_ffff;
        end else if (v < SAT_MIN) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
        end else begin
            s.ovf = 1'b0;
            s.val = v[31:0];
        end
        return s;
    endfunction

endpackage

>>> sv/fvpt_divsqrt.sv
`timescale 1ns / 1ps
// Radix-2 shift-subtract unit: saturating magnitude divide or integer square root.
module fvpt_divsqrt (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fvpt_pkg::fvpt_dreq_t    req,
    output fvpt_pkg::fvpt_dres_t    res
);
    import fvpt_pkg::*;

    typedef enum logic [2:0] {
        DS_IDLE = 3'b001,
        DS_RUN  = 3'b010,
        DS_DONE = 3'b100
    } ds_state_t;

    ds_state_t   state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] work_reg, work_next;
    logic [31:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic        sqrt_reg, sqrt_next;
    logic        neg_reg, neg_next;
    logic        sat_reg, sat_next;
    logic        zero_reg, zero_next;

    logic [64:0] rem2, trial, diff;
    logic        ge;

    assign rem2  = sqrt_reg ? {rem_reg[62:0], work_reg[63:62]} : {rem_reg, work_reg[63]};
    assign trial = sqrt_reg ? {31'b0, q_reg, 2'b01} : {1'b0, den_reg};
    assign ge    = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        work_next  = work_reg;
        q_next     = q_reg;
        den_next   = den_reg;
        sqrt_next  = sqrt_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            DS_IDLE: begin
                if (req.start) begin
                    sqrt_next = req.is_sqrt;
                    neg_next  = req.neg;
                    den_next  = req.den;
                    sat_next  = 1'b0;
                    zero_next = 1'b0;
                    q_next    = '0;
                    cnt_next  = '0;
                    if (req.is_sqrt) begin
                        rem_next   = '0;
                        work_next  = req.num;
                        state_next = DS_RUN;
                    end else if (req.num == 64'd0) begin
                        zero_next  = 1'b1;
                        state_next = DS_DONE;
                    end else if ({32'b0, req.num[63:32]} >= req.den) begin
                        sat_next   = 1'b1;
                        state_next = DS_DONE;
                    end else begin
                        rem_next   = {32'b0, req.num[63:32]};
                        work_next  = {req.num[31:0], 32'b0};
                        state_next = DS_RUN;
                    end
                end
            end
            DS_RUN: begin
                rem_next  = ge ? diff[63:0] : rem2[63:0];
                q_next    = {q_reg[30:0], ge};
                work_next = sqrt_reg ? {work_reg[61:0], 2'b00} : {work_reg[62:0], 1'b0};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_BITS - 1)) begin
                    state_next = DS_DONE;
                end
            end
            DS_DONE: begin
                state_next = DS_IDLE;
            end
            default: begin
                state_next = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        q_reg    <= q_next;
        den_reg  <= den_next;
        sqrt_reg <= sqrt_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        res.done = (state_reg == DS_DONE);
        res.root = q_reg;
        res.clip = 1'b0;
        res.quot = '0;
        if (zero_reg) begin
            res.quot = '0;
        end else if (sat_reg) begin
            res.clip = 1'b1;
            res.quot = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else if (neg_reg) begin
            if (q_reg > 32'h8000_0000) begin
                res.clip = 1'b1;
                res.quot = 32'h8000_0000;
            end else begin
                res.quot = 32'(-q_reg);
            end
        end else if (q_reg[31]) begin
            res.clip = 1'b1;
            res.quot = 32'h7fff_ffff;
        end else begin
            res.quot = q_reg;
        end
    end

endmodule

>>> sv/fvpt_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC: sine/cosine of a turn phase, or angle of a vector.
module fvpt_cordic (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fvpt_pkg::fvpt_creq_t    req,
    output fvpt_pkg::fvpt_cres_t    res
);
    import fvpt_pkg::*;

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_RUN  = 3'b010,
        CS_DONE = 3'b100
    } cs_state_t;

    cs_state_t          state_reg, state_next;
    logic signed [65:0] x_reg, x_next;
    logic signed [65:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               vec_reg, vec_next;
    logic               flip_reg, flip_next;

    logic signed [65:0] xs, ys, xe, ye;
    logic signed [33:0] z0, ang;
    logic               pos;

    assign xs  = x_reg >>> i_reg;
    assign ys  = y_reg >>> i_reg;
    assign ang = 34'(CORDIC_ANGLE[i_reg]);
    assign pos = vec_reg ? !(y_reg > 66'sd0) : !z_reg[33];
    assign z0  = 34'($signed(req.phase));
    assign xe  = 66'($signed(req.px)) <<< 30;
    assign ye  = 66'($signed(req.py)) <<< 30;

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        vec_next   = vec_reg;
        flip_next  = flip_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (req.start) begin
                    vec_next   = req.vec;
                    flip_next  = 1'b0;
                    i_next     = '0;
                    state_next = CS_RUN;
                    if (!req.vec) begin
                        x_next = CORDIC_GAIN;
                        y_next = '0;
                        z_next = z0;
                        if (z0 > QUARTER_TURN) begin
                            z_next    = z0 - HALF_TURN;
                            flip_next = 1'b1;
                        end else if (z0 < -QUARTER_TURN) begin
                            z_next    = z0 + HALF_TURN;
                            flip_next = 1'b1;
                        end
                    end else if (req.px == 32'd0 && req.py == 32'd0) begin
                        z_next     = '0;
                        state_next = CS_DONE;
                    end else if (req.px[31]) begin
                        if (!req.py[31]) begin
                            x_next = ye;
                            y_next = -xe;
                            z_next = QUARTER_TURN;
                        end else begin
                            x_next = -ye;
                            y_next = xe;
                            z_next = -QUARTER_TURN;
                        end
                    end else begin
                        x_next = xe;
                        y_next = ye;
                        z_next = '0;
                    end
                end
            end
            CS_RUN: begin
                if (pos) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - ang;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + ang;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        vec_reg  <= vec_next;
        flip_reg <= flip_next;
    end

    assign res.done    = (state_reg == CS_DONE);
    assign res.sin_q30 = flip_reg ? 33'(-y_reg) : 33'(y_reg);
    assign res.cos_q30 = flip_reg ? 33'(-x_reg) : 33'(x_reg);
    assign res.angle   = z_reg;

endmodule

>>> sv/flame_variation_point_transform.sv
`timescale 1ns / 1ps
// Top level: transform table, sequencer, shared multiplier, divide/root and CORDIC units.
//
//  channel | direction | ports                      | content
//  s_      | in        | s_tvalid s_tready s_tdata  | tuser: mode; tdata: item fields
//          |           | s_tuser                    |
//  m_      | out       | m_tvalid m_tready m_tdata  | tdata: result x, y; tuser: clipped
//          |           | m_tuser                    |
//
// An evaluate transfer reads the transform's twelve table words, then the 32-step root and
// divide unit and the 24-step CORDIC dominate, the multiplier one product a cycle.
// Reset clears the sequencer and output valid; the table is undefined until loaded.
// s_tready is high only when the sequencer is idle; a held result stalls the next one only
// at its final write.
module flame_variation_point_transform (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // transform_index, word_index, word_value, point_x, point_y
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_x, result_y
    output logic         m_tuser    // clipped
);
    import fvpt_pkg::*;

    typedef enum logic [33:0] {
        ST_IDLE  = 34'h000000001,
        ST_RDMEM = 34'h000000002,
        ST_AF1   = 34'h000000004,
        ST_AF2   = 34'h000000008,
        ST_AF3   = 34'h000000010,
        ST_AF4   = 34'h000000020,
        ST_AF5   = 34'h000000040,
        ST_SQ0   = 34'h000000080,
        ST_SQ1   = 34'h000000100,
        ST_SQ2   = 34'h000000200,
        ST_SQ3   = 34'h000000400,
        ST_SQ4   = 34'h000000800,
        ST_SQ5   = 34'h000001000,
        ST_VSEL  = 34'h000002000,
        ST_SN1   = 34'h000004000,
        ST_SN2   = 34'h000008000,
        ST_SN3   = 34'h000010000,
        ST_SP1   = 34'h000020000,
        ST_SP2   = 34'h000040000,
        ST_SW1   = 34'h000080000,
        ST_SW2   = 34'h000100000,
        ST_SW3   = 34'h000200000,
        ST_SW4   = 34'h000400000,
        ST_SW5   = 34'h000800000,
        ST_SW6   = 34'h001000000,
        ST_SW7   = 34'h002000000,
        ST_HS1   = 34'h004000000,
        ST_HS2   = 34'h008000000,
        ST_PL1   = 34'h010000000,
        ST_PL2   = 34'h020000000,
        ST_W1    = 34'h040000000,
        ST_W2    = 34'h080000000,
        ST_W3    = 34'h100000000,
        ST_DONE  = 34'h200000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] coef_mem [MEM_DEPTH];
    logic [31:0] coef_reg [WORDS_PER_TRANSFORM];
    logic [31:0] rd_data_reg;

    logic [MEM_AW-1:0]  base_reg, base_next;
    logic [3:0]         rd_cnt_reg, rd_cnt_next;
    logic signed [31:0] x_in_reg, x_in_next, y_in_reg, y_in_next;
    logic signed [51:0] acc_reg, acc_next;
    logic signed [31:0] u_reg, u_next, v_reg, v_next;
    logic [63:0]        musq_reg, musq_next, mvsq_reg, mvsq_next, muv_reg, muv_next;
    logic [63:0]        r2_reg, r2_next;
    logic [31:0]        r_reg, r_next;
    logic [2:0]         var_reg, var_next;
    logic               half_reg, half_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [32:0] sin_reg, sin_next, cos_reg, cos_next;
    logic [31:0]        tmp_reg, tmp_next;
    logic signed [63:0] p1_reg, p1_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic               clip_reg, clip_next;
    logic signed [65:0] prod_reg, prod_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic               m_clip_reg, m_clip_next;

    logic               s_fire;
    logic [3:0]         in_tidx, in_widx;
    logic [MEM_AW-1:0]  wr_addr, rd_addr;
    logic               tidx_ok;
    logic [31:0]        mu, mv;
    logic signed [31:0] w_sel;
    logic signed [32:0] mul_a, mul_b;
    logic signed [51:0] aff_sum;
    logic               sq_ge;
    sat_t               aff_sat, swx_sat, swy_sat, wt_sat, pol_sat, fin_x_sat, fin_y_sat;

    fvpt_dreq_t dreq;
    fvpt_dres_t dres;
    fvpt_creq_t creq;
    fvpt_cres_t cres;

    fvpt_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .res     (dres)
    );

    fvpt_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .res     (cres)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_tidx  = s_tdata[3:0];
    assign in_widx  = s_tdata[7:4];
    assign tidx_ok  = {5'b0, in_tidx} < 9'(MAX_TRANSFORMS);
    assign wr_addr  = MEM_AW'(MEM_AW'(in_tidx) * MEM_AW'(WORDS_PER_TRANSFORM) + MEM_AW'(in_widx));
    assign rd_addr  = base_reg + MEM_AW'(rd_cnt_reg);

    assign mu    = u_reg[31] ? 32'(-u_reg) : 32'(u_reg);
    assign mv    = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
    assign w_sel = coef_reg[4'(WEIGHT_BASE) + 4'(var_reg)];
    assign sq_ge = musq_reg >= mvsq_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_AF1: begin mul_a = 33'($signed(coef_reg[0])); mul_b = 33'(x_in_reg); end
            ST_AF2: begin mul_a = 33'($signed(coef_reg[1])); mul_b = 33'(y_in_reg); end
            ST_AF3: begin mul_a = 33'($signed(coef_reg[3])); mul_b = 33'(x_in_reg); end
            ST_AF4: begin mul_a = 33'($signed(coef_reg[4])); mul_b = 33'(y_in_reg); end
            ST_SQ0: begin mul_a = $signed({1'b0, mu}); mul_b = $signed({1'b0, mu}); end
            ST_SQ1: begin mul_a = $signed({1'b0, mv}); mul_b = $signed({1'b0, mv}); end
            ST_SQ2: begin mul_a = $signed({1'b0, mu}); mul_b = $signed({1'b0, mv}); end
            ST_SN1: begin
                mul_a = half_reg ? 33'(v_reg) : 33'(u_reg);
                mul_b = TURNS_PER_RAD;
            end
            ST_SW1: begin mul_a = $signed({1'b0, r2_reg[63:32]}); mul_b = TURNS_PER_RAD; end
            ST_SW2: begin mul_a = $signed({1'b0, r2_reg[31:0]}); mul_b = TURNS_PER_RAD; end
            ST_SW5: begin mul_a = 33'(u_reg); mul_b = sin_reg; end
            ST_SW6: begin mul_a = 33'(v_reg); mul_b = cos_reg; end
            ST_W1:  begin mul_a = 33'(w_sel); mul_b = 33'(vx_reg); end
            ST_W2:  begin mul_a = 33'(w_sel); mul_b = 33'(vy_reg); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign aff_sum = acc_reg + 52'(prod_reg >>> 16)
                   + 52'($signed(state_reg == ST_AF3 ? coef_reg[2] : coef_reg[5]));
    assign aff_sat   = sat32(68'(aff_sum));
    assign swx_sat   = sat32((68'(p1_reg) - 68'(prod_reg)) >>> 30);
    assign swy_sat   = sat32((68'(p1_reg) + 68'(prod_reg)) >>> 30);
    assign wt_sat    = sat32(68'(prod_reg >>> 16));
    assign pol_sat   = sat32(68'($signed({1'b0, r_reg})) - ONE_Q16);
    assign fin_x_sat = sat32(68'(sum_x_reg));
    assign fin_y_sat = sat32(68'(sum_y_reg));

    always_comb begin
        dreq         = '0;
        dreq.start   = (state_reg == ST_SQ4) || (state_reg == ST_SP1) || (state_reg == ST_HS1);
        dreq.is_sqrt = (state_reg == ST_SQ4);
        if (state_reg == ST_SQ4) begin
            dreq.num = r2_reg;
        end else if (state_reg == ST_SP1) begin
            dreq.num = half_reg ? {mv, 32'b0} : {mu, 32'b0};
            dreq.den = r2_reg;
            dreq.neg = half_reg ? v_reg[31] : u_reg[31];
        end else begin
            dreq.den = {32'b0, r_reg};
            if (half_reg) begin
                dreq.num = {muv_reg[62:0], 1'b0};
                dreq.neg = u_reg[31] ^ v_reg[31];
            end else begin
                dreq.num = sq_ge ? musq_reg - mvsq_reg : mvsq_reg - musq_reg;
                dreq.neg = !sq_ge;
            end
        end
    end

    always_comb begin
        creq       = '0;
        creq.start = (state_reg == ST_SN2) || (state_reg == ST_SW3) || (state_reg == ST_PL1);
        creq.vec   = (state_reg == ST_PL1);
        creq.phase = (state_reg == ST_SW3) ? tmp_reg + prod_reg[63:32] : prod_reg[47:16];
        creq.px    = v_reg;
        creq.py    = u_reg;
    end

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        rd_cnt_next   = rd_cnt_reg;
        x_in_next     = x_in_reg;
        y_in_next     = y_in_reg;
        acc_next      = acc_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        musq_next     = musq_reg;
        mvsq_next     = mvsq_reg;
        muv_next      = muv_reg;
        r2_next       = r2_reg;
        r_next        = r_reg;
        var_next      = var_reg;
        half_next     = half_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        sin_next      = sin_reg;
        cos_next      = cos_reg;
        tmp_next      = tmp_reg;
        p1_next       = p1_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        clip_next     = clip_reg;
        m_x_next      = m_x_reg;
        m_y_next      = m_y_reg;
        m_clip_next   = m_clip_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == MODE_EVAL) begin
                    base_next   = MEM_AW'(MEM_AW'(in_tidx) * MEM_AW'(WORDS_PER_TRANSFORM));
                    rd_cnt_next = '0;
                    x_in_next   = s_tdata[71:40];
                    y_in_next   = s_tdata[103:72];
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    clip_next   = 1'b0;
                    var_next    = '0;
                    state_next  = tidx_ok ? ST_RDMEM : ST_DONE;
                end
            end
            ST_RDMEM: begin
                rd_cnt_next = rd_cnt_reg + 4'd1;
                if (rd_cnt_reg == 4'(WORDS_PER_TRANSFORM)) begin
                    state_next = ST_AF1;
                end
            end
            ST_AF1: state_next = ST_AF2;
            ST_AF2: begin
                acc_next   = 52'(prod_reg >>> 16);
                state_next = ST_AF3;
            end
            ST_AF3: begin
                u_next     = aff_sat.val;
                clip_next  = clip_reg | aff_sat.ovf;
                state_next = ST_AF4;
            end
            ST_AF4: begin
                acc_next   = 52'(prod_reg >>> 16);
                state_next = ST_AF5;
            end
            ST_AF5: begin
                v_next     = aff_sat.val;
                clip_next  = clip_reg | aff_sat.ovf;
                state_next = ST_SQ0;
            end
            ST_SQ0: state_next = ST_SQ1;
            ST_SQ1: begin
                musq_next  = prod_reg[63:0];
                state_next = ST_SQ2;
            end
            ST_SQ2: begin
                mvsq_next  = prod_reg[63:0];
                state_next = ST_SQ3;
            end
            ST_SQ3: begin
                muv_next   = prod_reg[63:0];
                r2_next    = musq_reg + mvsq_reg;
                state_next = ST_SQ4;
            end
            ST_SQ4: state_next = ST_SQ5;
            ST_SQ5: begin
                if (dres.done) begin
                    r_next     = dres.root;
                    state_next = ST_VSEL;
                end
            end
            ST_VSEL: begin
                half_next = 1'b0;
                if (var_reg == 3'(VARIATION_COUNT)) begin
                    state_next = ST_DONE;
                end else if (w_sel == 32'sd0) begin
                    var_next = var_reg + 3'd1;
                end else begin
                    case (var_reg)
                        VAR_LINEAR: begin
                            vx_next    = u_reg;
                            vy_next    = v_reg;
                            state_next = ST_W1;
                        end
                        VAR_SINUS:  state_next = ST_SN1;
                        VAR_SPHERE: state_next = ST_SP1;
                        VAR_SWIRL:  state_next = ST_SW1;
                        VAR_HORSE:  state_next = ST_HS1;
                        VAR_POLAR:  state_next = ST_PL1;
                        default:    var_next = var_reg + 3'd1;
                    endcase
                end
            end
            ST_SN1: state_next = ST_SN2;
            ST_SN2: state_next = ST_SN3;
            ST_SN3: begin
                if (cres.done) begin
                    if (half_reg) begin
                        vy_next    = 32'($signed(cres.sin_q30) >>> 14);
                        state_next = ST_W1;
                    end else begin
                        vx_next    = 32'($signed(cres.sin_q30) >>> 14);
                        half_next  = 1'b1;
                        state_next = ST_SN1;
                    end
                end
            end
            ST_SP1: state_next = ST_SP2;
            ST_SP2: begin
                if (dres.done) begin
                    clip_next = clip_reg | dres.clip;
                    if (half_reg) begin
                        vy_next    = dres.quot;
                        state_next = ST_W1;
                    end else begin
                        vx_next    = dres.quot;
                        half_next  = 1'b1;
                        state_next = ST_SP1;
                    end
                end
            end
            ST_SW1: state_next = ST_SW2;
            ST_SW2: begin
                tmp_next   = prod_reg[31:0];
                state_next = ST_SW3;
            end
            ST_SW3: state_next = ST_SW4;
            ST_SW4: begin
                if (cres.done) begin
                    sin_next   = cres.sin_q30;
                    cos_next   = cres.cos_q30;
                    state_next = ST_SW5;
                end
            end
            ST_SW5: state_next = ST_SW6;
            ST_SW6: begin
                p1_next    = prod_reg[63:0];
                state_next = ST_SW7;
            end
            ST_SW7: begin
                vx_next    = swx_sat.val;
                vy_next    = swy_sat.val;
                clip_next  = clip_reg | swx_sat.ovf | swy_sat.ovf;
                state_next = ST_W1;
            end
            ST_HS1: state_next = ST_HS2;
            ST_HS2: begin
                if (dres.done) begin
                    clip_next = clip_reg | dres.clip;
                    if (half_reg) begin
                        vy_next    = dres.quot;
                        state_next = ST_W1;
                    end else begin
                        vx_next    = dres.quot;
                        half_next  = 1'b1;
                        state_next = ST_HS1;
                    end
                end
            end
            ST_PL1: state_next = ST_PL2;
            ST_PL2: begin
                if (cres.done) begin
                    vx_next    = 32'($signed(cres.angle) >>> 15);
                    vy_next    = pol_sat.val;
                    clip_next  = clip_reg | pol_sat.ovf;
                    state_next = ST_W1;
                end
            end
            ST_W1: state_next = ST_W2;
            ST_W2: begin
                sum_x_next = sum_x_reg + SUM_W'($signed(wt_sat.val));
                clip_next  = clip_reg | wt_sat.ovf;
                state_next = ST_W3;
            end
            ST_W3: begin
                sum_y_next = sum_y_reg + SUM_W'($signed(wt_sat.val));
                clip_next  = clip_reg | wt_sat.ovf;
                var_next   = var_reg + 3'd1;
                state_next = ST_VSEL;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_x_next      = fin_x_sat.val;
                    m_y_next      = fin_y_sat.val;
                    m_clip_next   = clip_reg | fin_x_sat.ovf | fin_y_sat.ovf;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == MODE_LOAD && tidx_ok
            && {4'b0, in_widx} < 8'(WORDS_PER_TRANSFORM)) begin
            coef_mem[wr_addr] <= s_tdata[39:8];
        end
        rd_data_reg <= coef_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RDMEM && rd_cnt_reg != 4'd0) begin
            coef_reg[rd_cnt_reg - 4'd1] <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        base_reg   <= base_next;
        rd_cnt_reg <= rd_cnt_next;
        x_in_reg   <= x_in_next;
        y_in_reg   <= y_in_next;
        acc_reg    <= acc_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        musq_reg   <= musq_next;
        mvsq_reg   <= mvsq_next;
        muv_reg    <= muv_next;
        r2_reg     <= r2_next;
        r_reg      <= r_next;
        var_reg    <= var_next;
        half_reg   <= half_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        sin_reg    <= sin_next;
        cos_reg    <= cos_next;
        tmp_reg    <= tmp_next;
        p1_reg     <= p1_next;
        sum_x_reg  <= sum_x_next;
        sum_y_reg  <= sum_y_next;
        clip_reg   <= clip_next;
        prod_reg   <= prod_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
        m_clip_reg <= m_clip_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_clip_reg;

endmodule

>>> bench/fvpt_result_checker.sv
`timescale 1ns / 1ps
// Checker for the flame variation point transform: table copy, point predictor, result compare.
module fvpt_result_checker
    import fvpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,   // transform_index, word_index, word_value, point_x, point_y
    input  logic         s_tuser,   // mode
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,   // result_x, result_y
    input  logic         m_tuser,   // clipped
    output int           fail_count,
    output int           pending
);

    typedef struct {
        int x;
        int y;
        bit clip;
    } point_res_t;

    int         coeff_table [MEM_DEPTH];
    point_res_t expected_points [$];

    function automatic int clamp32(longint v, inout bit clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'h8000_0000;
        end
        return int'(v);
    endfunction

    function automatic int udiv_clamp(bit neg, longint unsigned num, longint unsigned den,
                                      inout bit clip);
        longint unsigned q;
        if (num == 0) return 0;
        if (den == 0) begin
            clip = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        q = num / den;
        if (neg) begin
            if (q > 64'd2147483648) begin
                clip = 1'b1;
                return 32'h8000_0000;
            end
            return int'(-longint'(q));
        end
        if (q > 64'd2147483647) begin
            clip = 1'b1;
            return 32'h7fff_ffff;
        end
        return int'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // phase in Q0.32 turns, outputs in Q30
    function automatic void sin_cos(input logic [31:0] phase, output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit     flip;
        z = longint'({32'd0, phase});
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({34'd0, CORDIC_ANGLE[i]});
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({34'd0, CORDIC_ANGLE[i]});
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint vec_angle(int px, int py);
        longint x, y, z, t, xs, ys;
        x = longint'(px) * 64'sd1073741824;
        y = longint'(py) * 64'sd1073741824;
        z = 0;
        if (px == 0 && py == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 64'sd1073741824;
            end else begin
                x = -y;
                y = t;
                z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({34'd0, CORDIC_ANGLE[i]});
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({34'd0, CORDIC_ANGLE[i]});
            end
        end
        return z;
    endfunction

    function automatic point_res_t predict_point(int t, int px, int py);
        point_res_t      res;
        int              base, u, v, vx, vy, w;
        longint unsigned mu, mv, r2, r;
        longint          sum_x, sum_y, s, c, p;
        logic [63:0]     pb;
        logic [127:0]    wide;
        bit              clip;
        base = t * WORDS_PER_TRANSFORM;
        clip = 1'b0;
        sum_x = 0;
        sum_y = 0;
        u = clamp32(((longint'(coeff_table[base]) * px) >>> 16)
                  + ((longint'(coeff_table[base + 1]) * py) >>> 16)
                  + longint'(coeff_table[base + 2]), clip);
        v = clamp32(((longint'(coeff_table[base + 3]) * px) >>> 16)
                  + ((longint'(coeff_table[base + 4]) * py) >>> 16)
                  + longint'(coeff_table[base + 5]), clip);
        mu = (u < 0) ? longint'(-longint'(u)) : longint'(u);
        mv = (v < 0) ? longint'(-longint'(v)) : longint'(v);
        r2 = mu * mu + mv * mv;
        r = int_sqrt(r2);
        for (int i = 0; i < VARIATION_COUNT; i++) begin
            w = coeff_table[base + WEIGHT_BASE + i];
            if (w != 0) begin
                vx = 0;
                vy = 0;
                case (3'(i))
                    VAR_LINEAR: begin
                        vx = u;
                        vy = v;
                    end
                    VAR_SINUS: begin
                        p = longint'(u) * 64'sd683565276;
                        pb = p;
                        sin_cos(pb[47:16], s, c);
                        vx = clamp32(s >>> 14, clip);
                        p = longint'(v) * 64'sd683565276;
                        pb = p;
                        sin_cos(pb[47:16], s, c);
                        vy = clamp32(s >>> 14, clip);
                    end
                    VAR_SPHERE: begin
                        vx = udiv_clamp(u < 0, mu << 32, r2, clip);
                        vy = udiv_clamp(v < 0, mv << 32, r2, clip);
                    end
                    VAR_SWIRL: begin
                        wide = {64'd0, r2} * 128'd683565276;
                        sin_cos(wide[63:32], s, c);
                        vx = clamp32((longint'(u) * s - longint'(v) * c) >>> 30, clip);
                        vy = clamp32((longint'(u) * s + longint'(v) * c) >>> 30, clip);
                    end
                    VAR_HORSE: begin
                        if (mu * mu >= mv * mv)
                            vx = udiv_clamp(1'b0, mu * mu - mv * mv, r, clip);
                        else
                            vx = udiv_clamp(1'b1, mv * mv - mu * mu, r, clip);
                        vy = udiv_clamp((u < 0) != (v < 0), 64'd2 * mu * mv, r, clip);
                    end
                    VAR_POLAR: begin
                        vx = clamp32(vec_angle(v, u) >>> 15, clip);
                        vy = clamp32(longint'(r) - 64'sd65536, clip);
                    end
                    default: ;
                endcase
                sum_x = sum_x + clamp32((longint'(w) * vx) >>> 16, clip);
                sum_y = sum_y + clamp32((longint'(w) * vy) >>> 16, clip);
            end
        end
        res.x = clamp32(sum_x, clip);
        res.y = clamp32(sum_y, clip);
        res.clip = clip;
        return res;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        point_res_t exp_pt;
        if (!aresetn) begin
            expected_points.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected result transfer x %h y %h", m_tdata[31:0], m_tdata[63:32]);
                    fail_count = fail_count + 1;
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (m_tdata[31:0] !== exp_pt.x) begin
                        $error("result_x expected %h actual %h", exp_pt.x, m_tdata[31:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tdata[63:32] !== exp_pt.y) begin
                        $error("result_y expected %h actual %h", exp_pt.y, m_tdata[63:32]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tuser !== exp_pt.clip) begin
                        $error("clipped expected %b actual %b", exp_pt.clip, m_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_LOAD) begin
                    if (s_tdata[7:4] < WORDS_PER_TRANSFORM)
                        coeff_table[s_tdata[3:0] * WORDS_PER_TRANSFORM + s_tdata[7:4]] =
                            int'(s_tdata[39:8]);
                end else begin
                    expected_points.push_back(predict_point(int'(s_tdata[3:0]),
                        int'(s_tdata[71:40]), int'(s_tdata[103:72])));
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

>>> bench/flame_variation_point_transform_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, stream stimulus with random idling, and the final verdict.
module flame_variation_point_transform_tb;
    import fvpt_pkg::*;

    localparam int ONE = 65536;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // transform_index, word_index, word_value, point_x, point_y
    logic         s_tuser;   // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // result_x, result_y
    logic         m_tuser;   // clipped
    int           fail_count;
    int           pending;
    int           tx_idle;
    int           rx_idle;

    flame_variation_point_transform u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fvpt_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(logic mode, logic [3:0] t, logic [3:0] k, int val, int px, int py);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {py, px, val, k, t};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic int rand_word();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3, 4: return int'($urandom);
            default: return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        endcase
    endfunction

    function automatic int rand_weight();
        if ($urandom_range(9) < 4) return 0;
        return rand_word();
    endfunction

    task automatic load_word(int t, int k, int val);
        send_item(MODE_LOAD, 4'(t), 4'(k), val, int'($urandom), int'($urandom));
    endtask

    task automatic eval_point(int t, int px, int py);
        send_item(MODE_EVAL, 4'(t), 4'($urandom), int'($urandom), px, py);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = MODE_LOAD;
        s_tdata  = '0;
        tx_idle  = 27;
        rx_idle  = 67;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // table setup: origin map, identity maps with each variation alone, all six, clipping, random rest
        for (int t = 0; t < MAX_TRANSFORMS; t++) begin
            for (int k = 0; k < WORDS_PER_TRANSFORM; k++) begin
                int val;
                if (t == 0)
                    val = (k >= WEIGHT_BASE) ? ONE : 0;
                else if (t <= 7 && k < WEIGHT_BASE)
                    val = (k == 0 || k == 4) ? ONE : 0;
                else if (t <= 6)
                    val = (k - WEIGHT_BASE == t - 1) ? ONE : 0;
                else if (t == 7)
                    val = ONE;
                else if (t == 8)
                    val = (k < 3) ? 32'h7fff_ffff : ((k < 6) ? 32'h8000_0000 : 32'h7fff_ffff);
                else
                    val = (k >= WEIGHT_BASE) ? rand_weight() : rand_word();
                load_word(t, k, val);
            end
        end
        for (int k = WORDS_PER_TRANSFORM; k < 16; k++) load_word(7, k, int'($urandom));

        eval_point(0, 32'h7fff_ffff, 32'h8000_0000);
        eval_point(0, 0, 0);
        for (int t = 1; t <= 7; t++) eval_point(t, 3 * ONE / 2, -ONE / 2);
        eval_point(7, 0, 0);
        eval_point(7, 32'h7fff_ffff, 32'h7fff_ffff);
        eval_point(7, 32'h8000_0000, 32'h8000_0000);
        eval_point(7, -ONE, 0);
        eval_point(7, 0, -ONE);
        eval_point(8, 32'h7fff_ffff, 32'h7fff_ffff);
        eval_point(8, 32'h8000_0000, 32'h8000_0000);
        eval_point(5, 32'h7fff_ffff, 32'h8000_0000);
        eval_point(6, 2 * ONE, -3 * ONE);

        for (int n = 0; n < 1640; n++) begin
            if (n == 550) begin
                tx_idle = 67;
                rx_idle = 27;
            end else if (n == 1100) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (n == 350 || n == 900) begin
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            if ($urandom_range(9) < 3) begin
                int k;
                k = $urandom_range(15);
                load_word($urandom_range(15), k,
                          (k >= WEIGHT_BASE && k < WORDS_PER_TRANSFORM) ? rand_weight()
                                                                        : rand_word());
            end else begin
                eval_point($urandom_range(15), rand_word(), rand_word());
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
